// File: rtl/rwla_pkg.sv
`default_nettype none

package rwla_pkg;

    typedef enum logic [1:0] {
        CMD_START_READ  = 2'd0,
        CMD_END_READ    = 2'd1,
        CMD_START_WRITE = 2'd2,
        CMD_END_WRITE   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_GRANT  = 2'd0,
        ST_MISUSE = 2'd1,
        ST_FULL   = 2'd2
    } result_status_t;

    // where a result's id comes from
    typedef enum logic [1:0] {
        SRC_REQ = 2'd0,
        SRC_RQ  = 2'd1,
        SRC_WQ  = 2'd2
    } emit_src_t;

    localparam int ID_W = 4;
    localparam int READERS_W = 5;
    localparam logic [READERS_W-1:0] READERS_MAX = 5'd31;
    // grants handed out by one writer release
    localparam int MAX_GRANTS = 16;
    localparam int DRAIN_W = $clog2(MAX_GRANTS + 1);

    typedef struct packed {
        logic           latch;
        logic           rd_push;
        logic           wr_push;
        logic           rd_pop;
        logic           wr_pop;
        logic           readers_inc;
        logic           readers_dec;
        logic           writer_set;
        logic           writer_clr;
        logic           drain_clr;
        logic           emit;
        emit_src_t      emit_src;
        logic           emit_write;
        result_status_t emit_status;
        logic           emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd_code;
        logic      bad_id;
        logic      writer_active;
        logic      readers_zero;
        logic      readers_one;
        logic      readers_full;
        logic      rq_empty;
        logic      rq_full;
        logic      wq_empty;
        logic      wq_full;
        logic      drain_more;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/rwla_ctrl.sv
`default_nettype none

module rwla_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire rwla_pkg::dp_stat_t stat,
    output rwla_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RPOP,
        S_WPOP,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   more_reg, more_next;
    logic   out_valid_reg;
    logic   is_wr;

    assign is_wr     = (stat.cmd_code == rwla_pkg::CMD_START_WRITE) ||
                       (stat.cmd_code == rwla_pkg::CMD_END_WRITE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        more_next  = more_reg;
        cmd        = '0;
        cmd.emit_src    = rwla_pkg::SRC_REQ;
        cmd.emit_status = rwla_pkg::ST_GRANT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.emit_write = is_wr;
                cmd.emit_last  = 1'b1;
                more_next      = 1'b0;
                state_next     = S_IDLE;
                if (stat.bad_id)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = rwla_pkg::ST_MISUSE;
                    state_next      = S_OUT;
                end
                else
                begin
                    case (stat.cmd_code)
                        rwla_pkg::CMD_START_READ:
                        begin
                            if (stat.writer_active)
                            begin
                                if (stat.rq_full)
                                begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_status = rwla_pkg::ST_FULL;
                                    state_next      = S_OUT;
                                end
                                else
                                begin
                                    cmd.rd_push = 1'b1;
                                end
                            end
                            else if (stat.readers_full)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = rwla_pkg::ST_MISUSE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                cmd.readers_inc = 1'b1;
                                cmd.emit        = 1'b1;
                                state_next      = S_OUT;
                            end
                        end
                        rwla_pkg::CMD_END_READ:
                        begin
                            if (stat.readers_zero)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = rwla_pkg::ST_MISUSE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                cmd.readers_dec = 1'b1;
                                if (stat.readers_one && !stat.writer_active && !stat.wq_empty)
                                begin
                                    cmd.writer_set = 1'b1;
                                    state_next     = S_WPOP;
                                end
                            end
                        end
                        rwla_pkg::CMD_START_WRITE:
                        begin
                            if (!stat.readers_zero || stat.writer_active)
                            begin
                                if (stat.wq_full)
                                begin
                                    cmd.emit        = 1'b1;
                                    cmd.emit_status = rwla_pkg::ST_FULL;
                                    state_next      = S_OUT;
                                end
                                else
                                begin
                                    cmd.wr_push = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.writer_set = 1'b1;
                                cmd.emit       = 1'b1;
                                state_next     = S_OUT;
                            end
                        end
                        rwla_pkg::CMD_END_WRITE:
                        begin
                            if (!stat.writer_active)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = rwla_pkg::ST_MISUSE;
                                state_next      = S_OUT;
                            end
                            else if (!stat.rq_empty)
                            begin
                                cmd.writer_clr = 1'b1;
                                if (!stat.readers_full)
                                begin
                                    cmd.drain_clr = 1'b1;
                                    state_next    = S_RPOP;
                                end
                            end
                            else if (!stat.wq_empty)
                            begin
                                // writer flag stays set for the next writer
                                state_next = S_WPOP;
                            end
                            else
                            begin
                                cmd.writer_clr = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RPOP:
            begin
                cmd.rd_pop      = 1'b1;
                cmd.readers_inc = 1'b1;
                cmd.emit        = 1'b1;
                cmd.emit_src    = rwla_pkg::SRC_RQ;
                cmd.emit_last   = !stat.drain_more;
                more_next       = stat.drain_more;
                state_next      = S_OUT;
            end
            S_WPOP:
            begin
                cmd.wr_pop     = 1'b1;
                cmd.emit       = 1'b1;
                cmd.emit_src   = rwla_pkg::SRC_WQ;
                cmd.emit_write = 1'b1;
                cmd.emit_last  = 1'b1;
                more_next      = 1'b0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = more_reg ? S_RPOP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            more_reg      <= more_next;
            out_valid_reg <= (state_next == S_OUT);
        end
    end

endmodule

`default_nettype wire

// File: rtl/rwla_dpath.sv
`default_nettype none

module rwla_dpath #(
    parameter int AGENTS             = 16,
    parameter int READER_QUEUE_DEPTH = 16,
    parameter int WRITER_QUEUE_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   command,
    input  wire logic [rwla_pkg::ID_W-1:0]    requester,
    input  wire rwla_pkg::ctrl_cmd_t          cmd,
    output rwla_pkg::dp_stat_t                stat,
    output logic [rwla_pkg::ID_W-1:0]         grant_id,
    output logic                              grant_write,
    output logic [1:0]                        status,
    output logic                              last
);

    localparam int RQ_AW = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
    localparam int RQ_CW = $clog2(READER_QUEUE_DEPTH + 1);
    localparam int WQ_AW = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;
    localparam int WQ_CW = $clog2(WRITER_QUEUE_DEPTH + 1);
    localparam int ID_W  = rwla_pkg::ID_W;
    localparam int RD_W  = rwla_pkg::READERS_W;
    localparam int DR_W  = rwla_pkg::DRAIN_W;

    rwla_pkg::cmd_code_t cmd_reg;
    logic [ID_W-1:0]     req_reg;

    logic [RD_W-1:0]  readers_reg, readers_next;
    logic             writer_reg, writer_next;
    logic [RQ_CW-1:0] rq_count_reg, rq_count_next;
    logic [RQ_AW-1:0] rq_head_reg, rq_head_next;
    logic [WQ_CW-1:0] wq_count_reg, wq_count_next;
    logic [WQ_AW-1:0] wq_head_reg, wq_head_next;
    logic [DR_W-1:0]  drained_reg, drained_next;

    logic [ID_W-1:0] rq_mem [READER_QUEUE_DEPTH];
    logic [ID_W-1:0] wq_mem [WRITER_QUEUE_DEPTH];
    logic [ID_W-1:0] rq_rd_reg, wq_rd_reg;

    logic [RQ_CW:0]   rq_sum;
    logic [RQ_AW-1:0] rq_tail;
    logic [WQ_CW:0]   wq_sum;
    logic [WQ_AW-1:0] wq_tail;

    logic [ID_W-1:0] id_reg;
    logic            write_reg;
    logic [1:0]      status_reg;
    logic            last_reg;

    // tail slot = (head + count) mod depth; the sum stays below twice the depth
    always_comb
    begin
        rq_sum = (RQ_CW+1)'(rq_head_reg) + (RQ_CW+1)'(rq_count_reg);
        if (rq_sum >= (RQ_CW+1)'(READER_QUEUE_DEPTH))
        begin
            rq_sum = rq_sum - (RQ_CW+1)'(READER_QUEUE_DEPTH);
        end
        rq_tail = rq_sum[RQ_AW-1:0];
        wq_sum = (WQ_CW+1)'(wq_head_reg) + (WQ_CW+1)'(wq_count_reg);
        if (wq_sum >= (WQ_CW+1)'(WRITER_QUEUE_DEPTH))
        begin
            wq_sum = wq_sum - (WQ_CW+1)'(WRITER_QUEUE_DEPTH);
        end
        wq_tail = wq_sum[WQ_AW-1:0];
    end

    always_comb
    begin
        stat.cmd_code      = cmd_reg;
        stat.bad_id        = (32'(req_reg) >= AGENTS);
        stat.writer_active = writer_reg;
        stat.readers_zero  = (readers_reg == '0);
        stat.readers_one   = (readers_reg == RD_W'(1));
        stat.readers_full  = (readers_reg >= rwla_pkg::READERS_MAX);
        stat.rq_empty      = (rq_count_reg == '0);
        stat.rq_full       = (rq_count_reg >= RQ_CW'(READER_QUEUE_DEPTH));
        stat.wq_empty      = (wq_count_reg == '0);
        stat.wq_full       = (wq_count_reg >= WQ_CW'(WRITER_QUEUE_DEPTH));
        // another reader may follow the one being popped now
        stat.drain_more    = (rq_count_reg > RQ_CW'(1)) &&
                             (drained_reg < DR_W'(rwla_pkg::MAX_GRANTS - 1)) &&
                             (readers_reg < (rwla_pkg::READERS_MAX - RD_W'(1)));
    end

    always_comb
    begin
        readers_next  = readers_reg;
        writer_next   = writer_reg;
        rq_count_next = rq_count_reg;
        rq_head_next  = rq_head_reg;
        wq_count_next = wq_count_reg;
        wq_head_next  = wq_head_reg;
        drained_next  = drained_reg;
        if (cmd.readers_inc)
        begin
            readers_next = readers_reg + RD_W'(1);
        end
        else if (cmd.readers_dec)
        begin
            readers_next = readers_reg - RD_W'(1);
        end
        if (cmd.writer_set)
        begin
            writer_next = 1'b1;
        end
        else if (cmd.writer_clr)
        begin
            writer_next = 1'b0;
        end
        if (cmd.rd_push)
        begin
            rq_count_next = rq_count_reg + RQ_CW'(1);
        end
        else if (cmd.rd_pop)
        begin
            rq_count_next = rq_count_reg - RQ_CW'(1);
            rq_head_next  = (rq_head_reg == RQ_AW'(READER_QUEUE_DEPTH - 1)) ?
                            '0 : rq_head_reg + RQ_AW'(1);
        end
        if (cmd.wr_push)
        begin
            wq_count_next = wq_count_reg + WQ_CW'(1);
        end
        else if (cmd.wr_pop)
        begin
            wq_count_next = wq_count_reg - WQ_CW'(1);
            wq_head_next  = (wq_head_reg == WQ_AW'(WRITER_QUEUE_DEPTH - 1)) ?
                            '0 : wq_head_reg + WQ_AW'(1);
        end
        if (cmd.drain_clr)
        begin
            drained_next = '0;
        end
        else if (cmd.rd_pop)
        begin
            drained_next = drained_reg + DR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readers_reg  <= '0;
            writer_reg   <= 1'b0;
            rq_count_reg <= '0;
            rq_head_reg  <= '0;
            wq_count_reg <= '0;
            wq_head_reg  <= '0;
            drained_reg  <= '0;
        end
        else
        begin
            readers_reg  <= readers_next;
            writer_reg   <= writer_next;
            rq_count_reg <= rq_count_next;
            rq_head_reg  <= rq_head_next;
            wq_count_reg <= wq_count_next;
            wq_head_reg  <= wq_head_next;
            drained_reg  <= drained_next;
        end
    end

    // wait queues: one write port at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.rd_push)
        begin
            rq_mem[rq_tail] <= req_reg;
        end
        rq_rd_reg <= rq_mem[rq_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_push)
        begin
            wq_mem[wq_tail] <= req_reg;
        end
        wq_rd_reg <= wq_mem[wq_head_reg];
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= rwla_pkg::cmd_code_t'(command);
            req_reg <= requester;
        end
        if (cmd.emit)
        begin
            case (cmd.emit_src)
                rwla_pkg::SRC_RQ: id_reg <= rq_rd_reg;
                rwla_pkg::SRC_WQ: id_reg <= wq_rd_reg;
                default:          id_reg <= req_reg;
            endcase
            write_reg  <= cmd.emit_write;
            status_reg <= cmd.emit_status;
            last_reg   <= cmd.emit_last;
        end
    end

    assign grant_id    = id_reg;
    assign grant_write = write_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: rtl/readers_writer_lock_arbiter.sv
// Readers-writer lock arbiter.
// Input channel (in_valid/in_stall): one item per request, command (start read,
// end read, start write, end write) plus requester id. Output channel
// (out_valid/out_stall): grant or error items with grant_id, grant_write,
// status (grant, misuse, queue full) and last on the final item of a request.
// One request is handled at a time: in_stall is high from the cycle after
// acceptance until the request's final result item has been taken.
// The first result item is loaded into the result register by the decide step,
// or by the pop step after it when it comes off a wait queue. A request that
// produces no item lets the next one in once its decide step is done. A writer
// release hands out up to 16 queued readers, each through a pop step and then an output step.
// A stalled result holds its payload and blocks further work until taken.
// Reset (rst_n, async, active low) clears the reader count, the writer flag and
// both queue pointers; queue storage is not cleared.
`default_nettype none

module readers_writer_lock_arbiter #(
    parameter int AGENTS             = 16,
    parameter int READER_QUEUE_DEPTH = 16,
    parameter int WRITER_QUEUE_DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [3:0] requester,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      grant_id,
    output logic            grant_write,
    output logic [1:0]      status,
    output logic            last
);

    rwla_pkg::ctrl_cmd_t cmd;
    rwla_pkg::dp_stat_t  stat;

    // sequencer: decides each request, walks the reader drain
    rwla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // lock state, wait queues and result register
    rwla_dpath #(
        .AGENTS             (AGENTS),
        .READER_QUEUE_DEPTH (READER_QUEUE_DEPTH),
        .WRITER_QUEUE_DEPTH (WRITER_QUEUE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .requester   (requester),
        .cmd         (cmd),
        .stat        (stat),
        .grant_id    (grant_id),
        .grant_write (grant_write),
        .status      (status),
        .last        (last)
    );

endmodule

`default_nettype wire
